// ===== rtl/pdt_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Periodic task dispatcher package
// Operation codes, controller states and the payload types of both channels.
// ----------------------------------------------------------------------------
package pdt_pkg;

  typedef enum logic [1:0] {
    OP_TICK    = 2'd0,
    OP_EXECUTE = 2'd1,
    OP_ADD     = 2'd2,
    OP_POST    = 2'd3
  } op_e;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_SCAN = 4'b0010,
    ST_EXEC = 4'b0100,
    ST_EMIT = 4'b1000
  } state_e;

  typedef struct packed {
    op_e         op;
    logic [31:0] period;
    logic [7:0]  handle;
  } in_t;

  typedef struct packed {
    logic       event_fired;
    logic [7:0] event_handle;
    logic       task_fired;
    logic [7:0] task_handle;
    logic [3:0] task_slot;
    logic       full_error;
    logic       overrun;
  } out_t;

endpackage
`default_nettype wire

// ===== rtl/pdt_task_table.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Periodic task dispatcher task table
// Holds period, handle and time stamp of every task in synchronous memories
// and flags whether the entry read last has run past its period.
// ----------------------------------------------------------------------------
module pdt_task_table
  import pdt_pkg::*;
#(
  parameter int unsigned MaxTasks = 16,
  parameter int unsigned SlotW    = 4
) (
  input  wire logic             clk_i,
  input  wire logic             wr_entry_i,
  input  wire logic             wr_stamp_i,
  input  wire logic [SlotW-1:0] wr_addr_i,
  input  wire logic [31:0]      wr_period_i,
  input  wire logic [7:0]       wr_handle_i,
  input  wire logic [31:0]      wr_stamp_val_i,
  input  wire logic [SlotW-1:0] rd_addr_i,
  input  wire logic [31:0]      tick_i,
  output logic [7:0]            rd_handle_o,
  output logic                  expired_o
);

  logic [39:0] info_mem [MaxTasks];
  logic [31:0] stamp_mem [MaxTasks];
  logic [39:0] info_q;
  logic [31:0] stamp_q;
  logic [31:0] elapsed;

  always_ff @(posedge clk_i) begin
    if (wr_entry_i) begin
      info_mem[wr_addr_i] <= {wr_handle_i, wr_period_i};
    end
    if (wr_entry_i || wr_stamp_i) begin
      stamp_mem[wr_addr_i] <= wr_stamp_val_i;
    end
    info_q  <= info_mem[rd_addr_i];
    stamp_q <= stamp_mem[rd_addr_i];
  end

  assign elapsed     = tick_i - stamp_q;
  assign expired_o   = elapsed > info_q[31:0];
  assign rd_handle_o = info_q[39:32];

endmodule
`default_nettype wire

// ===== rtl/pdt_event_stack.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Periodic task dispatcher event stack
// Last-in first-out store of one-shot event handles with its fill count.
// ----------------------------------------------------------------------------
module pdt_event_stack
  import pdt_pkg::*;
#(
  parameter int unsigned MaxEvents = 16,
  parameter int unsigned AddrW     = 4,
  parameter int unsigned CountW    = 5
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push_i,
  input  wire logic [7:0] push_data_i,
  input  wire logic       pop_i,
  output logic            full_o,
  output logic            empty_o,
  output logic [7:0]      top_o
);

  logic [7:0]        stack_mem [MaxEvents];
  logic [CountW-1:0] count_q, count_d;
  logic [CountW-1:0] top_idx;
  logic [7:0]        top_q;

  assign full_o  = count_q == CountW'(MaxEvents);
  assign empty_o = count_q == '0;
  assign top_idx = count_q - CountW'(1);
  assign top_o   = top_q;

  always_comb begin
    count_d = count_q;
    if (push_i) begin
      count_d = count_q + CountW'(1);
    end else if (pop_i) begin
      count_d = count_q - CountW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      stack_mem[count_q[AddrW-1:0]] <= push_data_i;
    end
    top_q <= stack_mem[top_idx[AddrW-1:0]];
  end

endmodule
`default_nettype wire

// ===== rtl/periodic_task_dispatcher.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Periodic task dispatcher
// Add and post go from idle straight to the emit state; execute passes
// through the exec state first, and tick may scan the task entries in the
// scan state first. A new item is taken only in idle, once the last result
// has been emitted; the task scan reads one table entry per cycle. Reset
// clears all control state; the memories are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
module periodic_task_dispatcher
  import pdt_pkg::*;
#(
  parameter int unsigned MaxTasks  = 16,
  parameter int unsigned MaxEvents = 16
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  input  wire in_t  in_data_i,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  output out_t      out_data_o
);

  localparam int unsigned SlotW   = (MaxTasks > 1) ? $clog2(MaxTasks) : 1;
  localparam int unsigned TCountW = $clog2(MaxTasks + 1);
  localparam int unsigned EAddrW  = (MaxEvents > 1) ? $clog2(MaxEvents) : 1;
  localparam int unsigned ECountW = $clog2(MaxEvents + 1);

  state_e             state_q, state_d;
  logic [31:0]        tick_q, tick_d;
  logic [TCountW-1:0] task_cnt_q, task_cnt_d;
  logic [SlotW-1:0]   scan_ptr_q, scan_ptr_d;
  logic [TCountW-1:0] remain_q, remain_d;
  logic               task_pend_q, task_pend_d;
  logic [SlotW-1:0]   pend_slot_q, pend_slot_d;
  logic               event_pend_q, event_pend_d;
  out_t               res_q, res_d;
  out_t               out_q;
  logic               out_valid_q;

  logic               accept;
  logic               emit;
  logic [SlotW:0]     ptr_inc;
  logic [SlotW:0]     task_cnt_ext;
  logic [SlotW-1:0]   ptr_next;
  logic [SlotW+3:0]   slot_ext;

  logic               wr_entry;
  logic               wr_stamp;
  logic [SlotW-1:0]   wr_addr;
  logic [31:0]        wr_stamp_val;
  logic [SlotW-1:0]   rd_addr;
  logic [7:0]         rd_handle;
  logic               expired;

  logic               push;
  logic               pop;
  logic               stack_full;
  logic               stack_empty;
  logic [7:0]         stack_top;

  assign in_ready_o  = state_q == ST_IDLE;
  assign accept      = in_valid_i && in_ready_o;
  assign emit        = (state_q == ST_EMIT) && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign ptr_inc      = {1'b0, scan_ptr_q} + (SlotW + 1)'(1);
  assign task_cnt_ext = (SlotW + 1)'(task_cnt_q);
  assign ptr_next     = (ptr_inc < task_cnt_ext) ? ptr_inc[SlotW-1:0] : '0;
  assign slot_ext     = {4'b0000, pend_slot_q};

  always_comb begin
    state_d      = state_q;
    tick_d       = tick_q;
    task_cnt_d   = task_cnt_q;
    scan_ptr_d   = scan_ptr_q;
    remain_d     = remain_q;
    task_pend_d  = task_pend_q;
    pend_slot_d  = pend_slot_q;
    event_pend_d = event_pend_q;
    res_d        = res_q;
    wr_entry     = 1'b0;
    wr_stamp     = 1'b0;
    wr_addr      = task_cnt_q[SlotW-1:0];
    wr_stamp_val = tick_q - 32'(task_cnt_q);
    rd_addr      = scan_ptr_q;
    push         = 1'b0;
    pop          = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          res_d   = '0;
          state_d = ST_EMIT;
          unique case (in_data_i.op)
            OP_TICK: begin
              tick_d = tick_q + 32'd1;
              if (task_pend_q || event_pend_q) begin
                res_d.overrun = 1'b1;
              end else begin
                event_pend_d = !stack_empty;
                if (task_cnt_q != '0) begin
                  remain_d = task_cnt_q;
                  state_d  = ST_SCAN;
                end
              end
            end
            OP_EXECUTE: begin
              rd_addr = pend_slot_q;
              state_d = ST_EXEC;
            end
            OP_ADD: begin
              if (task_cnt_q < TCountW'(MaxTasks)) begin
                wr_entry   = 1'b1;
                task_cnt_d = task_cnt_q + TCountW'(1);
              end else begin
                res_d.full_error = 1'b1;
              end
            end
            OP_POST: begin
              if (!stack_full) begin
                push = 1'b1;
              end else begin
                res_d.full_error = 1'b1;
              end
            end
            default: begin
              state_d = ST_EMIT;
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (expired) begin
          wr_stamp     = 1'b1;
          wr_addr      = scan_ptr_q;
          wr_stamp_val = tick_q;
          task_pend_d  = 1'b1;
          pend_slot_d  = scan_ptr_q;
          state_d      = ST_EMIT;
        end else begin
          scan_ptr_d = ptr_next;
          rd_addr    = ptr_next;
          remain_d   = remain_q - TCountW'(1);
          if (remain_q == TCountW'(1)) begin
            state_d = ST_EMIT;
          end
        end
      end
      ST_EXEC: begin
        if (event_pend_q && !stack_empty) begin
          pop                = 1'b1;
          res_d.event_fired  = 1'b1;
          res_d.event_handle = stack_top;
        end
        event_pend_d = 1'b0;
        if (task_pend_q) begin
          res_d.task_fired  = 1'b1;
          res_d.task_handle = rd_handle;
          res_d.task_slot   = slot_ext[3:0];
          task_pend_d       = 1'b0;
        end
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (emit) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      tick_q       <= '0;
      task_cnt_q   <= '0;
      scan_ptr_q   <= '0;
      remain_q     <= '0;
      task_pend_q  <= 1'b0;
      pend_slot_q  <= '0;
      event_pend_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      tick_q       <= tick_d;
      task_cnt_q   <= task_cnt_d;
      scan_ptr_q   <= scan_ptr_d;
      remain_q     <= remain_d;
      task_pend_q  <= task_pend_d;
      pend_slot_q  <= pend_slot_d;
      event_pend_q <= event_pend_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    if (emit) begin
      out_q <= res_q;
    end
  end

  pdt_task_table #(
    .MaxTasks(MaxTasks),
    .SlotW   (SlotW)
  ) u_task_table (
    .clk_i         (clk_i),
    .wr_entry_i    (wr_entry),
    .wr_stamp_i    (wr_stamp),
    .wr_addr_i     (wr_addr),
    .wr_period_i   (in_data_i.period),
    .wr_handle_i   (in_data_i.handle),
    .wr_stamp_val_i(wr_stamp_val),
    .rd_addr_i     (rd_addr),
    .tick_i        (tick_q),
    .rd_handle_o   (rd_handle),
    .expired_o     (expired)
  );

  pdt_event_stack #(
    .MaxEvents(MaxEvents),
    .AddrW    (EAddrW),
    .CountW   (ECountW)
  ) u_event_stack (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i(in_data_i.handle),
    .pop_i      (pop),
    .full_o     (stack_full),
    .empty_o    (stack_empty),
    .top_o      (stack_top)
  );

endmodule
`default_nettype wire
